>>> rtl/range_median_mean_turn_detect_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the range filter block
// Each macro wraps one concurrent assertion on the rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef RANGE_MEDIAN_MEAN_TURN_DETECT_UNIT_MACROS_SVH
`define RANGE_MEDIAN_MEAN_TURN_DETECT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RMM_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define RMM_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define RMM_ASSERT_IMP(label, clk, rst_n, a, c)
`define RMM_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/rmm_pkg.sv
// ----------------------------------------------------------------------------
// rmm_pkg
// Shared constants, types and cell control for the range filter block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rmm_pkg;
	localparam int HistoryDepth = 9;
	localparam int MedianTaps = 5;
	localparam int MeanTaps = 4;
	localparam int SlotW = $clog2(HistoryDepth);
	localparam int MeanSumW = 16 + $clog2(MeanTaps + 1);
	localparam logic [15:0] U16All = 16'hFFFF;

	localparam logic [2:0] RegClampLow = 3'd0;
	localparam logic [2:0] RegClampHigh = 3'd1;
	localparam logic [2:0] RegValidLimit = 3'd2;
	localparam logic [2:0] RegTrendDelta = 3'd3;
	localparam logic [2:0] RegHoldTime = 3'd4;
	localparam logic [2:0] RegFailLimit = 3'd5;

	// Command that the controller broadcasts to every cell of the chain.
	typedef struct packed {
		logic clear;    // reinit: zero all rings
		logic shift;    // rotate chain by one position
		logic load_raw; // write head of raw ring
		logic load_med; // write head of median ring
		logic load_smo; // write head of smooth ring
	} cell_ctl_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MED    = 6'b000010,
		ST_MEAN   = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_TURN   = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;
endpackage
`default_nettype wire

>>> rtl/rmm_cell.sv
// ----------------------------------------------------------------------------
// rmm_cell
// One history position: holds raw, median and smoothed words and hands them
// to the next position when the chain rotates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rmm_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rmm_pkg::cell_ctl_t ctl,
	input  wire logic              is_head,
	input  wire logic [15:0]       raw_in,
	input  wire logic [15:0]       med_in,
	input  wire logic [15:0]       smo_in,
	input  wire logic [15:0]       new_raw,
	input  wire logic [15:0]       new_med,
	input  wire logic [15:0]       new_smo,
	output logic [15:0]            raw_q,
	output logic [15:0]            med_q,
	output logic [15:0]            smo_q
);
	import rmm_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= '0;
			med_q <= '0;
			smo_q <= '0;
		end else if (ctl.clear) begin
			raw_q <= '0;
			med_q <= '0;
			smo_q <= '0;
		end else if (ctl.shift) begin
			raw_q <= raw_in;
			med_q <= med_in;
			smo_q <= smo_in;
		end else if (is_head) begin
			if (ctl.load_raw) raw_q <= new_raw;
			if (ctl.load_med) med_q <= new_med;
			if (ctl.load_smo) smo_q <= new_smo;
		end
	end
endmodule
`default_nettype wire

>>> rtl/rmm_chain.sv
// ----------------------------------------------------------------------------
// rmm_chain
// Ring of history cells. Cell zero always holds the current write slot;
// rotating the ring by one brings the oldest entry into cell zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rmm_chain (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rmm_pkg::cell_ctl_t ctl,
	input  wire logic [15:0]        new_raw,
	input  wire logic [15:0]        new_med,
	input  wire logic [15:0]        new_smo,
	output logic [15:0]             head_raw,
	output logic [15:0]             head_med,
	output logic [15:0]             head_smo
);
	import rmm_pkg::*;

	logic [15:0] raw_c [HistoryDepth];
	logic [15:0] med_c [HistoryDepth];
	logic [15:0] smo_c [HistoryDepth];

	// Cell i takes from cell i+1, last takes from cell zero: one full
	// rotation of HistoryDepth shifts restores the original order.
	for (genvar i = 0; i < HistoryDepth; i++) begin : g_cell
		localparam int Nx = (i + 1) % HistoryDepth;
		rmm_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .is_head(i == 0),
			.raw_in(raw_c[Nx]), .med_in(med_c[Nx]), .smo_in(smo_c[Nx]),
			.new_raw(new_raw), .new_med(new_med), .new_smo(new_smo),
			.raw_q(raw_c[i]), .med_q(med_c[i]), .smo_q(smo_c[i])
		);
	end

	assign head_raw = raw_c[0];
	assign head_med = med_c[0];
	assign head_smo = smo_c[0];
endmodule
`default_nettype wire

>>> rtl/range_median_mean_turn_detect_unit.sv
// A rejected word goes from acceptance to ST_OUT and then into the result register. An accepted
// word makes three passes over the cell ring in ST_MED, ST_MEAN and ST_SCAN, then goes through
// ST_TURN and ST_OUT into the result register; during warmup the median pass is skipped.
// Only one word is in the core at a time: a new word is taken only once the core is back in idle,
// and the result register frees the core while a result waits.
// Reset: arst_n clears all rings, counters and registers to reset values.
// ----------------------------------------------------------------------------
// range_median_mean_turn_detect_unit
// Range filter: validity check, clamp, median, mean and turning detection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "range_median_mean_turn_detect_unit_macros.svh"
module range_median_mean_turn_detect_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] distance_mm,
	input  wire logic        timed_out,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             accepted,
	output logic [15:0]      median_mm,
	output logic [15:0]      mean_mm,
	output logic             passed_min,
	output logic             passed_max,
	output logic             approaching,
	output logic [7:0]       bad_reads,
	output logic             reinit_request,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import rmm_pkg::*;

	// Configuration registers.
	logic [15:0] clamp_low_q, clamp_high_q, valid_limit_q, trend_delta_q, hold_time_q;
	logic [7:0]  fail_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_low_q   <= 16'd30;
			clamp_high_q  <= 16'd2000;
			valid_limit_q <= 16'd2000;
			trend_delta_q <= 16'd20;
			hold_time_q   <= 16'd200;
			fail_limit_q  <= 8'd10;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegClampLow:   clamp_low_q   <= cfg_data;
				RegClampHigh:  clamp_high_q  <= cfg_data;
				RegValidLimit: valid_limit_q <= cfg_data;
				RegTrendDelta: trend_delta_q <= cfg_data;
				RegHoldTime:   hold_time_q   <= cfg_data;
				RegFailLimit:  fail_limit_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Controller state.
	state_t      state_q;
	logic [4:0]  step_q;       // position within a rotation
	logic [SlotW-1:0] slot_q;
	logic        warm_q, closer_q, seen_q;
	logic [15:0] extreme_q;
	logic [31:0] turn_time_q, now_q;
	logic [7:0]  bad_q;
	logic [15:0] med_q, mean_q, lo_q, hi_q;
	logic [MeanSumW-1:0] sum_q;
	logic [15:0] mv_q [MedianTaps];  // sorted window for the median
	logic        pmin_q, pmax_q, reinit_q, acc_q;

	// Result register: holds the finished word so the core can take the next one.
	logic        out_valid_q;
	logic        res_acc_q, res_pmin_q, res_pmax_q, res_appr_q, res_reinit_q;
	logic [15:0] res_med_q, res_mean_q;
	logic [7:0]  res_bad_q;

	cell_ctl_t   ctl;
	logic [15:0] head_raw, head_med, head_smo;
	logic [15:0] med_new, smo_new;

	// The median and mean are ready at the first step of the following pass,
	// so the ring is loaded straight from their sources.
	assign med_new = warm_q ? med_q : mv_q[MedianTaps/2];
	assign smo_new = warm_q ? mean_q : 16'(sum_q / MeanTaps);

	logic        bad_in;
	logic [15:0] clamped;
	always_comb begin
		bad_in = timed_out || distance_mm == 16'd0 || distance_mm >= valid_limit_q;
		clamped = distance_mm;
		if (clamped < clamp_low_q) clamped = clamp_low_q;
		if (clamped > clamp_high_q) clamped = clamp_high_q;
	end

	rmm_chain u_chain (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.new_raw(clamped), .new_med(med_new), .new_smo(smo_new),
		.head_raw(head_raw), .head_med(head_med), .head_smo(head_smo)
	);

	logic in_acc, out_acc, load_res;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign load_res = (state_q == ST_OUT) && (!out_valid_q || out_acc);

	// The head cell always holds the current write slot, with older entries
	// following in reverse cell order. Each shift brings cell one into the
	// head, so after k shifts the head holds the entry written
	// (HistoryDepth - k) mod HistoryDepth words ago. The median pass looks
	// at the head from its first step; the mean pass shifts one step later.
	logic [4:0] pos, age;
	always_comb begin
		pos = (state_q == ST_MED) ? step_q : step_q - 5'd1;
		if (pos == 5'd0) age = 5'd0;
		else age = 5'(HistoryDepth) - pos;
	end

	// Insertion of a new value into the sorted median window.
	logic [15:0] ins [MedianTaps];
	always_comb begin
		ins[0] = (head_raw < mv_q[0]) ? head_raw : mv_q[0];
		for (int i = 1; i < MedianTaps; i++) begin
			if (head_raw >= mv_q[i]) ins[i] = mv_q[i];
			else if (head_raw >= mv_q[i-1]) ins[i] = head_raw;
			else ins[i] = mv_q[i-1];
		end
	end

	// Turning test: the extreme is first moved toward the ring min or max,
	// then the mean is compared with it as signed values.
	logic [31:0] since;
	logic        hold_ok;
	logic [15:0] ext_nx;
	logic signed [17:0] mean_s, up_s, dn_s;
	always_comb begin
		since   = now_q - turn_time_q;
		hold_ok = !seen_q || since >= {16'd0, hold_time_q};
		ext_nx  = extreme_q;
		if (closer_q && lo_q < extreme_q) ext_nx = lo_q;
		if (!closer_q && hi_q > extreme_q) ext_nx = hi_q;
		mean_s  = $signed({2'b00, mean_q});
		up_s    = $signed({2'b00, ext_nx}) + $signed({2'b00, trend_delta_q});
		dn_s    = $signed({2'b00, ext_nx}) - $signed({2'b00, trend_delta_q});
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && !bad_in) ctl.load_raw = 1'b1;
				if (in_acc && bad_in && bad_q >= fail_limit_q && fail_limit_q != 8'd0)
					ctl.clear = 1'b1;
			end
			ST_MED:  ctl.shift = 1'b1;
			ST_MEAN: begin
				ctl.shift = (step_q != 5'd0);
				ctl.load_med = (step_q == 5'd0);
			end
			ST_SCAN: begin
				ctl.shift = (step_q != 5'd0);
				ctl.load_smo = (step_q == 5'd0);
			end
			// One more shift moves the oldest entry into the head as the next write slot.
			ST_TURN: ctl.shift = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			slot_q <= '0;
			warm_q <= 1'b1;
			closer_q <= 1'b0;
			seen_q <= 1'b0;
			extreme_q <= '0;
			turn_time_q <= '0;
			now_q <= '0;
			bad_q <= '0;
			med_q <= '0;
			mean_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			sum_q <= '0;
			for (int i = 0; i < MedianTaps; i++) mv_q[i] <= '0;
			pmin_q <= 1'b0;
			pmax_q <= 1'b0;
			reinit_q <= 1'b0;
			acc_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						now_q <= now_ms;
						pmin_q <= 1'b0;
						pmax_q <= 1'b0;
						reinit_q <= 1'b0;
						if (bad_in) begin
							acc_q <= 1'b0;
							med_q <= '0;
							mean_q <= '0;
							if (bad_q < fail_limit_q) bad_q <= bad_q + 8'd1;
							else if (fail_limit_q != 8'd0) begin
								reinit_q <= 1'b1;
								slot_q <= '0;
								warm_q <= 1'b1;
								closer_q <= 1'b0;
								extreme_q <= '0;
								turn_time_q <= '0;
								seen_q <= 1'b0;
								bad_q <= '0;
							end
							state_q <= ST_OUT;
						end else begin
							acc_q <= 1'b1;
							bad_q <= '0;
							med_q <= clamped;
							mean_q <= clamped;
							for (int i = 0; i < MedianTaps; i++) mv_q[i] <= U16All;
							sum_q <= '0;
							step_q <= '0;
							state_q <= warm_q ? ST_MEAN : ST_MED;
						end
					end
				end
				ST_MED: begin
					// Visit each of the ring positions once; keep those young
					// enough to be median taps.
					if (age < 5'(MedianTaps)) mv_q <= ins;
					if (step_q == 5'(HistoryDepth - 1)) begin
						step_q <= '0;
						state_q <= ST_MEAN;
					end else step_q <= step_q + 5'd1;
				end
				ST_MEAN: begin
					if (step_q == 5'd0) begin
						med_q <= med_new;
						step_q <= 5'd1;
					end else begin
						if (age < 5'(MeanTaps))
							sum_q <= sum_q + MeanSumW'(head_med);
						if (step_q == 5'(HistoryDepth)) begin
							step_q <= '0;
							state_q <= ST_SCAN;
						end else step_q <= step_q + 5'd1;
					end
				end
				ST_SCAN: begin
					if (step_q == 5'd0) begin
						mean_q <= smo_new;
						lo_q <= U16All;
						hi_q <= '0;
						step_q <= 5'd1;
					end else begin
						if (head_smo < lo_q) lo_q <= head_smo;
						if (head_smo > hi_q) hi_q <= head_smo;
						if (step_q == 5'(HistoryDepth)) begin
							step_q <= '0;
							state_q <= ST_TURN;
						end else step_q <= step_q + 5'd1;
					end
				end
				ST_TURN: begin
					if (!warm_q && hold_ok) begin
						extreme_q <= ext_nx;
						if (closer_q) begin
							if (mean_s > up_s) begin
								pmin_q <= 1'b1; closer_q <= 1'b0;
								turn_time_q <= now_q; seen_q <= 1'b1;
							end
						end else if (mean_s < dn_s) begin
							pmax_q <= 1'b1; closer_q <= 1'b1;
							turn_time_q <= now_q; seen_q <= 1'b1;
						end
					end
					if (slot_q == SlotW'(HistoryDepth - 1)) begin
						slot_q <= '0;
						warm_q <= 1'b0;
					end else slot_q <= slot_q + SlotW'(1);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load_res) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The finished word moves into the result register once that is free or
	// being emptied in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_acc_q <= 1'b0;
			res_med_q <= '0;
			res_mean_q <= '0;
			res_pmin_q <= 1'b0;
			res_pmax_q <= 1'b0;
			res_appr_q <= 1'b0;
			res_bad_q <= '0;
			res_reinit_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
			res_acc_q <= acc_q;
			res_med_q <= med_q;
			res_mean_q <= mean_q;
			res_pmin_q <= pmin_q;
			res_pmax_q <= pmax_q;
			res_appr_q <= closer_q;
			res_bad_q <= bad_q;
			res_reinit_q <= reinit_q;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	assign accepted       = res_acc_q;
	assign median_mm      = res_med_q;
	assign mean_mm        = res_mean_q;
	assign passed_min     = res_pmin_q;
	assign passed_max     = res_pmax_q;
	assign approaching    = res_appr_q;
	assign bad_reads      = res_bad_q;
	assign reinit_request = res_reinit_q;

	// A turn pulse never comes with a rejected word.
	`RMM_ASSERT_IMP(a_pulse_acc, clk, arst_n, out_valid && (passed_min || passed_max), accepted)
	// Both turn directions never pulse together.
	`RMM_ASSERT_IMP(a_one_turn, clk, arst_n, out_valid, !(passed_min && passed_max))
	// A reinit leaves the bad count at zero.
	`RMM_ASSERT_IMP(a_reinit_cnt, clk, arst_n, out_valid && reinit_request, bad_reads == 8'd0)
	// A stalled result word stays in place.
	`RMM_ASSERT_NXT(a_hold_res, clk, arst_n, out_valid && out_stall, out_valid && $stable(median_mm) && $stable(mean_mm) && $stable(bad_reads))
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range filter regression
// Drives distance words with random idling on both sides, predicts each result
// with an independent model of the clamp, median, mean and turning logic, and
// compares every result word with its prediction in order.
// ----------------------------------------------------------------------------
module testbench;
	import rmm_pkg::*;

	localparam int Depth = 9;
	localparam int MedTaps = 5;
	localparam int AvgTaps = 4;
	localparam longint CycleLimit = 2000000;

	typedef struct packed {
		logic        acc;
		logic [15:0] med;
		logic [15:0] avg;
		logic        pmin;
		logic        pmax;
		logic        closer;
		logic [7:0]  bad;
		logic        reinit;
	} filt_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] distance_mm = '0;
	logic timed_out = 1'b0;
	logic [31:0] now_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic accepted;
	logic [15:0] median_mm;
	logic [15:0] mean_mm;
	logic passed_min;
	logic passed_max;
	logic approaching;
	logic [7:0] bad_reads;
	logic reinit_request;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	range_median_mean_turn_detect_unit uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register copies held by the predictor.
	logic [15:0] p_clamp_lo, p_clamp_hi, p_limit, p_delta, p_hold;
	logic [7:0]  p_fail_limit;
	// Filter state copies.
	logic [15:0] raw_hist [Depth];
	logic [15:0] med_hist [Depth];
	logic [15:0] smooth_hist [Depth];
	int          slot;
	logic        warm;
	logic        closer;
	logic [15:0] extreme;
	logic [31:0] turn_ms;
	logic        turn_seen;
	logic [7:0]  bad_cnt;

	filt_result_t expected_words[$];
	int  mismatches = 0;
	bit  stall_enable = 1'b1;
	bit  idle_enable = 1'b1;
	int  long_hold = 0;
	logic [31:0] clock_ms = 0;

	function automatic void clear_filter();
		for (int i = 0; i < Depth; i++) begin
			raw_hist[i] = '0;
			med_hist[i] = '0;
			smooth_hist[i] = '0;
		end
		slot = 0;
		warm = 1'b1;
		closer = 1'b0;
		extreme = '0;
		turn_ms = '0;
		turn_seen = 1'b0;
		bad_cnt = '0;
	endfunction

	function automatic int back_slot(int n);
		return (slot + 2 * Depth - (n % Depth)) % Depth;
	endfunction

	// Predicts the result word for one input word and advances the state.
	function automatic filt_result_t filter_step(logic [15:0] d, logic tmo, logic [31:0] t);
		filt_result_t r;
		logic [15:0] s, v[MedTaps], key, lo, hi;
		logic [18:0] sum;
		int j;
		r = '0;
		if (tmo || d == 0 || d >= p_limit) begin
			if (bad_cnt < p_fail_limit)
				bad_cnt++;
			else if (p_fail_limit > 0) begin
				clear_filter();
				r.reinit = 1'b1;
			end
		end else begin
			r.acc = 1'b1;
			bad_cnt = '0;
			s = d;
			if (s < p_clamp_lo) s = p_clamp_lo;
			if (s > p_clamp_hi) s = p_clamp_hi;
			raw_hist[slot] = s;
			if (warm)
				r.med = s;
			else begin
				for (int i = 0; i < MedTaps; i++) v[i] = raw_hist[back_slot(i)];
				for (int i = 1; i < MedTaps; i++) begin
					key = v[i];
					j = i;
					while (j > 0 && v[j - 1] > key) begin
						v[j] = v[j - 1];
						j--;
					end
					v[j] = key;
				end
				r.med = v[MedTaps / 2];
			end
			med_hist[slot] = r.med;
			if (warm)
				r.avg = r.med;
			else begin
				sum = '0;
				for (int i = 0; i < AvgTaps; i++) sum += med_hist[back_slot(i)];
				r.avg = 16'(sum / AvgTaps);
			end
			smooth_hist[slot] = r.avg;
			if (!warm && (!turn_seen || (t - turn_ms) >= {16'd0, p_hold})) begin
				lo = 16'hFFFF;
				hi = '0;
				for (int i = 0; i < Depth; i++) begin
					if (smooth_hist[i] > hi) hi = smooth_hist[i];
					if (smooth_hist[i] < lo) lo = smooth_hist[i];
				end
				if (closer) begin
					if (lo < extreme) extreme = lo;
					if (int'(r.avg) > int'(extreme) + int'(p_delta)) begin
						r.pmin = 1'b1;
						closer = 1'b0;
						turn_ms = t;
						turn_seen = 1'b1;
					end
				end else begin
					if (hi > extreme) extreme = hi;
					if (int'(r.avg) < int'(extreme) - int'(p_delta)) begin
						r.pmax = 1'b1;
						closer = 1'b1;
						turn_ms = t;
						turn_seen = 1'b1;
					end
				end
			end
			slot = (slot + 1) % Depth;
			if (slot == 0) warm = 1'b0;
		end
		r.closer = closer;
		r.bad = bad_cnt;
		return r;
	endfunction

	// Sends one word, with a random idle burst before it when allowed. Valid
	// stays up after the handshake until the next word or an idle burst.
	task automatic send_word(logic [15:0] d, logic tmo, logic [31:0] t);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		expected_words.push_back(filter_step(d, tmo, t));
		in_valid <= 1'b1;
		distance_mm <= d;
		timed_out <= tmo;
		now_ms <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		// Leave a quiet gap before the next phase.
		repeat (4 * Depth + 8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			RegClampLow:   p_clamp_lo = val;
			RegClampHigh:  p_clamp_hi = val;
			RegValidLimit: p_limit = val;
			RegTrendDelta: p_delta = val;
			RegHoldTime:   p_hold = val;
			RegFailLimit:  p_fail_limit = val[7:0];
			default: ;
		endcase
	endtask

	task automatic write_all(logic [15:0] lo, logic [15:0] hi, logic [15:0] lim,
			logic [15:0] dl, logic [15:0] hd, logic [7:0] fl);
		write_reg(RegClampLow, lo);
		write_reg(RegClampHigh, hi);
		write_reg(RegValidLimit, lim);
		write_reg(RegTrendDelta, dl);
		write_reg(RegHoldTime, hd);
		write_reg(RegFailLimit, {8'd0, fl});
		cfg_valid <= 1'b0;
	endtask

	// A smooth approach and retreat with noise and the odd bad read, the
	// shape that actually drives the turning detector.
	task automatic send_sweep(int n, int base, int span);
		int d;
		for (int i = 0; i < n; i++) begin
			clock_ms += $urandom_range(0, 80);
			d = base + (span * ((i % 40) < 20 ? (i % 20) : 20 - (i % 20))) / 20
				+ $urandom_range(0, 15);
			if ($urandom_range(0, 19) == 0)
				send_word(16'($urandom), 1'($urandom_range(0, 1)), clock_ms);
			else
				send_word(16'(d), 1'b0, clock_ms);
		end
	endtask

	task automatic test_directed();
		send_word(16'd0, 1'b0, 32'd0);
		send_word(16'd500, 1'b1, 32'd1);
		send_word(16'd2000, 1'b0, 32'd2);
		send_word(16'd1999, 1'b0, 32'd3);
		send_word(16'd1, 1'b0, 32'd4);
		send_word(16'hFFFF, 1'b0, 32'hFFFF_FFFF);
		for (int i = 0; i < 12; i++)
			send_word(16'(100 + 40 * i), 1'b0, 32'hFFFF_FF00 + 32'(50 * i));
		for (int i = 0; i < 12; i++) send_word(16'd0, 1'b1, 32'd100);
		wait_drained();
	endtask

	task automatic test_extreme_config();
		// Crossed clamps, widest valid limit, no reinit.
		write_all(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0);
		for (int i = 0; i < 20; i++)
			send_word(16'($urandom), 1'($urandom_range(0, 1)), $urandom);
		wait_drained();
		// Zero limit rejects everything; largest fail limit.
		write_all(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 8'hFF);
		for (int i = 0; i < 270; i++) send_word(16'($urandom), 1'b0, 32'(i));
		wait_drained();
		write_all(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 8'd1);
		clock_ms = 0;
		send_sweep(150, 200, 60000);
		wait_drained();
	endtask

	task automatic test_random_sweeps();
		for (int ph = 0; ph < 4; ph++) begin
			write_all(16'($urandom_range(0, 300)), 16'($urandom_range(1500, 65535)),
				16'($urandom_range(1000, 65535)), 16'($urandom_range(0, 100)),
				16'($urandom_range(0, 400)), 8'($urandom_range(0, 12)));
			send_sweep(130, $urandom_range(1, 800), $urandom_range(0, 2000));
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		// The receiver holds off for a long time while words keep coming.
		long_hold = 300;
		send_sweep(30, 300, 800);
		wait_drained();
		for (int i = 0; i < 60; i++)
			send_word(16'($urandom), 1'($urandom_range(0, 1)), $urandom);
		wait_drained();
	endtask

	task automatic test_no_idle();
		stall_enable = 1'b0;
		idle_enable = 1'b0;
		write_all(16'd30, 16'd2000, 16'd2000, 16'd20, 16'd200, 8'd10);
		send_sweep(150, 100, 1500);
		wait_drained();
	endtask

	// Receiver stall: random bursts, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (long_hold > 0) begin
			out_stall <= 1'b1;
			long_hold <= long_hold - 1;
		end else if (stall_enable && !out_stall && $urandom_range(0, 4) == 0)
			out_stall <= 1'b1;
		else if (out_stall && (!stall_enable || $urandom_range(0, 2) == 0))
			out_stall <= 1'b0;
	end

	// Result checker: each accepted result word against the oldest prediction.
	always @(posedge clk) begin
		filt_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {accepted, median_mm, mean_mm, passed_min, passed_max,
				approaching, bad_reads, reinit_request};
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: acc %b/%b med %0d/%0d mean %0d/%0d min %b/%b max %b/%b appr %b/%b bad %0d/%0d reinit %b/%b",
							want.acc, got.acc, want.med, got.med, want.avg, got.avg,
							want.pmin, got.pmin, want.pmax, got.pmax, want.closer,
							got.closer, want.bad, got.bad, want.reinit, got.reinit);
				end
			end
		end
	end

	// Watchdog on total run length.
	initial begin
		longint cycles;
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("range_median_mean_turn_detect_unit regression: fail");
		$finish;
	end

	initial begin
		p_clamp_lo = 16'd30;
		p_clamp_hi = 16'd2000;
		p_limit = 16'd2000;
		p_delta = 16'd20;
		p_hold = 16'd200;
		p_fail_limit = 8'd10;
		clear_filter();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extreme_config();
		test_random_sweeps();
		test_backpressure();
		test_no_idle();
		if (mismatches == 0 && expected_words.size() == 0)
			$display("range_median_mean_turn_detect_unit regression: pass");
		else
			$display("range_median_mean_turn_detect_unit regression: fail");
		$finish;
	end
endmodule

>>> sim.f
+incdir+rtl
rtl/rmm_pkg.sv
rtl/rmm_cell.sv
rtl/rmm_chain.sv
rtl/range_median_mean_turn_detect_unit.sv
tb/sv/testbench.sv
